/* rtl/lew_pkg.sv */
// Shared types, codes and sizes for the line editor with word wrap.
package lew_pkg;

    // Line buffer length and the widths that follow from it.
    localparam int LINE_LEN = 40;
    localparam int CUR_W    = $clog2(LINE_LEN + 1);
    localparam int ADDR_W   = $clog2(LINE_LEN);
    localparam int CMP_W    = 7;

    // Widths of the request and result fields.
    localparam int KEY_W    = 8;
    localparam int ACT_W    = 3;
    localparam int CNT_W    = 6;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd40;

    // Display command codes.
    localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BELL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INVALID = 3'd4;
    localparam logic [ACT_W-1:0] ACT_EXIT    = 3'd5;

    // Key codes with a meaning of their own.
    localparam logic [KEY_W-1:0] KEY_EOT   = 8'h04;
    localparam logic [KEY_W-1:0] KEY_BS    = 8'h08;
    localparam logic [KEY_W-1:0] KEY_NAK   = 8'h15;
    localparam logic [KEY_W-1:0] KEY_ETB   = 8'h17;
    localparam logic [KEY_W-1:0] KEY_ESC   = 8'h1b;
    localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;
    localparam logic [KEY_W-1:0] KEY_DEL   = 8'h7f;

    typedef logic [CUR_W-1:0] cur_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BELL_INV,
        S_INVALID,
        S_BELL,
        S_EXIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ERASE,
        S_NEWLINE,
        S_CP_RD,
        S_CP_WR,
        S_APPEND
    } state_t;

    typedef enum logic [3:0] {
        CMD_DROP,
        CMD_ESC,
        CMD_ESC_SKIP,
        CMD_HIGH,
        CMD_MB_SKIP,
        CMD_EXIT,
        CMD_BELL,
        CMD_WORD,
        CMD_BACK,
        CMD_KILL,
        CMD_WRAP,
        CMD_PUT
    } cmd_t;

    typedef enum logic [1:0] {
        SCAN_SPACES,
        SCAN_WORD,
        SCAN_WRAP
    } scan_mode_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] char_value;
        logic [CNT_W-1:0] erase_count;
        logic             last;
    } res_t;

endpackage

/* rtl/lew_ram.sv */
// Generic single-port RAM with registered read data.
module lew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds until the next read, so a waiting sequencer can reuse it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lew_core.sv */
// Editing sequencer: key decode, word scan unit and line buffer moves.
module lew_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [lew_pkg::CFG_W-1:0] line_width,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [lew_pkg::KEY_W-1:0] key_byte,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lew_pkg::res_t         res
);

    import lew_pkg::*;

    state_t     state_reg, state_next;
    scan_mode_t mode_reg, mode_next;
    cur_t       cursor_reg, cursor_next;
    cur_t       idx_reg, idx_next;
    cur_t       k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic       wrap_reg, wrap_next;
    logic [1:0] esc_reg, esc_next;
    logic       mb_reg, mb_next;
    logic       halted_reg, halted_next;

    cmd_t       cmd;
    state_t     stop_state;
    logic [CMP_W-1:0] eff_width;
    logic       wrap_needed;
    logic       is_space;
    logic       scan_go;
    logic       scan_stop;
    cur_t       scan_addr;
    cur_t       copy_src;
    cur_t       k_inc;

    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;

    lew_ram #(
        .WIDTH (KEY_W),
        .DEPTH (LINE_LEN)
    ) u_line (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Width register clamped to 1..LINE_LEN.
    always_comb
    begin
        if (line_width == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (CMP_W'(line_width) > CMP_W'(LINE_LEN))
        begin
            eff_width = CMP_W'(LINE_LEN);
        end
        else
        begin
            eff_width = CMP_W'(line_width);
        end
    end

    assign wrap_needed = CMP_W'(cursor_reg) >= eff_width;

    // Decode of the key offered at the input.
    always_comb
    begin
        priority if (halted_reg)
            cmd = CMD_DROP;
        else if (esc_reg == 2'd0 && key_byte == KEY_ESC)
            cmd = CMD_ESC;
        else if (esc_reg != 2'd0)
            cmd = CMD_ESC_SKIP;
        else if (!mb_reg && key_byte[KEY_W-1])
            cmd = CMD_HIGH;
        else if (mb_reg)
            cmd = CMD_MB_SKIP;
        else if (key_byte == KEY_EOT)
            cmd = (cursor_reg == '0) ? CMD_EXIT : CMD_BELL;
        else if (key_byte == KEY_ETB)
            cmd = CMD_WORD;
        else if (key_byte == KEY_BS || key_byte == KEY_DEL)
            cmd = (cursor_reg != '0) ? CMD_BACK : CMD_BELL;
        else if (key_byte == KEY_NAK)
            cmd = (cursor_reg != '0) ? CMD_KILL : CMD_DROP;
        else if (key_byte < KEY_SPACE)
            cmd = CMD_BELL;
        else if (wrap_needed)
            cmd = CMD_WRAP;
        else
            cmd = CMD_PUT;
    end

    // Scan unit: one character compare and one index step per visit.
    assign is_space  = ram_rdata == KEY_SPACE;
    assign scan_go   = (mode_reg == SCAN_SPACES) ? is_space : !is_space;
    assign scan_stop = (state_reg == S_SCAN_RD && idx_reg == '0) ||
                       (state_reg == S_SCAN_CHK && !scan_go);
    assign scan_addr = idx_reg - cur_t'(1);
    assign copy_src  = idx_reg + k_reg;
    assign k_inc     = k_reg + cur_t'(1);

    always_comb
    begin
        unique case (mode_reg)
            SCAN_SPACES: stop_state = S_SCAN_RD;
            SCAN_WORD:   stop_state = (cursor_reg != idx_reg) ? S_ERASE : S_IDLE;
            SCAN_WRAP:
            begin
                if (idx_reg == '0 || cursor_reg == idx_reg)
                    stop_state = S_NEWLINE;
                else
                    stop_state = S_ERASE;
            end
            default:     stop_state = S_IDLE;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_ESC, CMD_HIGH:  state_next = S_BELL_INV;
                        CMD_EXIT:           state_next = S_EXIT;
                        CMD_BELL:           state_next = S_BELL;
                        CMD_WORD, CMD_WRAP: state_next = S_SCAN_RD;
                        CMD_BACK, CMD_KILL: state_next = S_ERASE;
                        CMD_PUT:            state_next = S_APPEND;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_BELL_INV: if (res_ready) state_next = S_INVALID;
            S_INVALID:  if (res_ready) state_next = S_IDLE;
            S_BELL:     if (res_ready) state_next = S_IDLE;
            S_EXIT:     if (res_ready) state_next = S_IDLE;
            S_SCAN_RD:  state_next = scan_stop ? stop_state : S_SCAN_CHK;
            S_SCAN_CHK: state_next = scan_stop ? stop_state : S_SCAN_RD;
            S_ERASE:
            begin
                if (res_ready)
                    state_next = wrap_reg ? S_NEWLINE : S_IDLE;
            end
            S_NEWLINE:
            begin
                if (res_ready)
                    state_next = (cursor_reg != '0) ? S_CP_RD : S_APPEND;
            end
            S_CP_RD:    state_next = S_CP_WR;
            S_CP_WR:
            begin
                if (res_ready)
                    state_next = (k_inc == cursor_reg) ? S_APPEND : S_CP_RD;
            end
            S_APPEND:   if (res_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs: result offer, input ready and buffer port.
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '{action: ACT_BELL, char_value: '0, erase_count: '0, last: 1'b1};
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = key_reg;
        unique case (state_reg)
            S_IDLE:     in_ready = 1'b1;
            S_BELL_INV:
            begin
                res_valid = 1'b1;
                res.last  = 1'b0;
            end
            S_INVALID:
            begin
                res_valid  = 1'b1;
                res.action = ACT_INVALID;
            end
            S_BELL:     res_valid = 1'b1;
            S_EXIT:
            begin
                res_valid  = 1'b1;
                res.action = ACT_EXIT;
            end
            S_SCAN_RD:
            begin
                ram_en   = idx_reg != '0;
                ram_addr = scan_addr[ADDR_W-1:0];
            end
            S_SCAN_CHK: ;
            S_ERASE:
            begin
                res_valid       = 1'b1;
                res.action      = ACT_ERASE;
                res.erase_count = cnt_reg;
                res.last        = !wrap_reg;
            end
            S_NEWLINE:
            begin
                res_valid  = 1'b1;
                res.action = ACT_NEWLINE;
                res.last   = 1'b0;
            end
            S_CP_RD:
            begin
                ram_en   = 1'b1;
                ram_addr = copy_src[ADDR_W-1:0];
            end
            S_CP_WR:
            begin
                res_valid      = 1'b1;
                res.action     = ACT_ECHO;
                res.char_value = ram_rdata;
                res.last       = 1'b0;
                ram_en         = res_ready;
                ram_we         = 1'b1;
                ram_addr       = k_reg[ADDR_W-1:0];
                ram_wdata      = ram_rdata;
            end
            S_APPEND:
            begin
                res_valid      = 1'b1;
                res.action     = ACT_ECHO;
                res.char_value = key_reg;
                ram_en         = res_ready;
                ram_we         = 1'b1;
                ram_addr       = cursor_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        wrap_next   = wrap_reg;
        esc_next    = esc_reg;
        mb_next     = mb_reg;
        halted_next = halted_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = key_byte;
                    unique case (cmd)
                        CMD_ESC:
                        begin
                            esc_next    = 2'd2;
                            cursor_next = '0;
                        end
                        CMD_ESC_SKIP: esc_next = esc_reg - 2'd1;
                        CMD_HIGH:
                        begin
                            mb_next     = 1'b1;
                            cursor_next = '0;
                        end
                        CMD_MB_SKIP:  mb_next = 1'b0;
                        CMD_EXIT:     halted_next = 1'b1;
                        CMD_WORD:
                        begin
                            idx_next  = cursor_reg;
                            mode_next = SCAN_SPACES;
                        end
                        CMD_WRAP:
                        begin
                            idx_next  = cursor_reg;
                            mode_next = SCAN_WRAP;
                        end
                        CMD_BACK:
                        begin
                            cnt_next    = CNT_W'(1);
                            cursor_next = cursor_reg - cur_t'(1);
                            wrap_next   = 1'b0;
                        end
                        CMD_KILL:
                        begin
                            cnt_next    = CNT_W'(cursor_reg);
                            cursor_next = '0;
                            wrap_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD, S_SCAN_CHK:
            begin
                if (scan_stop)
                begin
                    k_next = '0;
                    unique case (mode_reg)
                        SCAN_SPACES: mode_next = SCAN_WORD;
                        SCAN_WORD:
                        begin
                            cnt_next    = CNT_W'(cursor_reg - idx_reg);
                            cursor_next = idx_reg;
                            wrap_next   = 1'b0;
                        end
                        SCAN_WRAP:
                        begin
                            // The word after the last space moves to the next line;
                            // a line with no space starts over empty.
                            cnt_next    = CNT_W'(cursor_reg - idx_reg);
                            cursor_next = (idx_reg == '0) ? '0 : cursor_reg - idx_reg;
                            wrap_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else if (state_reg == S_SCAN_CHK)
                begin
                    idx_next = idx_reg - cur_t'(1);
                end
            end
            S_CP_WR:    if (res_ready) k_next = k_inc;
            S_APPEND:   if (res_ready) cursor_next = cursor_reg + cur_t'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= SCAN_SPACES;
            cursor_reg <= '0;
            idx_reg    <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            wrap_reg   <= 1'b0;
            esc_reg    <= 2'd0;
            mb_reg     <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            wrap_reg   <= wrap_next;
            esc_reg    <= esc_next;
            mb_reg     <= mb_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

/* rtl/line_editor_with_word_wrap.sv */
// Top level of the line editor with word wrap: ports, width register, result register.
//
// Keyboard bytes arrive as requests on the s_ group (s_tdata = key byte). Each
// byte produces zero or more display commands on the m_ group; m_tlast marks the
// final command caused by a byte. m_tuser carries the command kind, m_tdata the
// echoed character and the erase count.
// The user must write the line width through cfg_valid/cfg_data only while the
// editor is idle; the block itself does not enforce this. cfg_ready is always high.
// Widths of 0 act as 1 and widths above the buffer length act as the buffer length.
// The editor takes one byte at a time: s_tready is high only in the idle state.
// A plain echo goes from the append state into the result register, and s_tready
// returns as the echo is loaded.
// Ctrl-W and word wrap scan the line backward with one read step and one compare
// step per character, and a wrap copies the moved word with one read step and one
// write step per character, as the single-port line buffer needs.
// When the receiver stalls, the finished command waits in the result register
// and the sequencer waits with it; nothing is dropped.
// Reset clears the cursor, the skip counters and the halt flag and loads a
// width of 40. The buffer itself is not cleared and needs no clearing pass.
module line_editor_with_word_wrap (
    input  logic        clk,
    input  logic        rst_n,
    // Line width register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,    // [5:0] line_width
    // Keyboard byte requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] key_byte
    // Display command results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] char_value, [13:8] erase_count, [15:14] zero
    output logic [2:0]  m_tuser,     // [2:0] action
    output logic        m_tlast
);

    import lew_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic             m_tvalid_reg;
    res_t             out_reg;
    res_t             res;
    logic             res_valid;
    logic             res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    lew_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (width_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .key_byte   (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The result register loads whenever it is empty or being drained this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.erase_count, out_reg.char_value};
    assign m_tuser  = out_reg.action;
    assign m_tlast  = out_reg.last;

endmodule
